@@ rtl/assert_macros.svh @@
// Assertion macros used by the core RTL file of the byte pattern scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/wbps_pkg.sv @@
// Types and constants of the wildcard byte pattern scanner.
`timescale 1ns / 1ps
package wbps_pkg;

   // Fixed field widths.
   localparam int unsigned ADDR_WIDTH  = 48;
   localparam int unsigned COUNT_WIDTH = 32;
   localparam int unsigned LEN_WIDTH   = 5;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned PAT_BYTES   = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WILDCARD     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE         = 3'd4;

   // Compare setup handed to one window cell.
   typedef struct packed {
      logic [7:0] pat_byte;
      logic       care;
   } wbps_tap_type;

endpackage

@@ rtl/wbps_cell.sv @@
// One window cell: holds one byte of the shift line and compares the byte moving in.
`timescale 1ns / 1ps
module wbps_cell
   import wbps_pkg::*;
(
   input  logic         clock,
   input  logic         shift_en,
   input  logic [7:0]   byte_in,
   input  wbps_tap_type tap,
   output logic [7:0]   byte_out,
   output logic         hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_mux;

   // The byte moves one cell further on every accepted beat.
   assign byte_in_mux = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_mux;
   end

   // The compare looks at the byte this cell holds after the shift.
   assign hit      = !tap.care || (byte_in == tap.pat_byte);
   assign byte_out = byte_ff;

endmodule

@@ rtl/wildcard_byte_pattern_scan_core.sv @@
// Top level of the wildcard byte pattern scanner.
//
// Bytes of a memory region arrive on the req_ channel, one per beat, with
// req_tlast on the final byte. A row of PATTERN_MAX cells shifts the bytes
// along, and each cell compares its byte to the pattern byte aligned to it,
// so the whole pattern is checked on every beat. The first match is kept.
// On the last byte one result beat leaves on the rsp_ channel: rsp_tuser is
// the found flag and rsp_tdata the match address (region base plus offset,
// wrapping at 48 bits, zero when nothing was found).
// A byte is taken every cycle unless stalled; the result appears in the cycle
// after the last byte is accepted, held in an output register. While that
// register holds a result that the receiver has not taken, req_tready stays
// low; when the receiver takes it in the same cycle, a new byte is accepted
// as well. Registers are written through the csr_ channel, which is always
// ready; write them only while no region is in flight (the block does not
// enforce it). Reset clears the byte counter, the match flag and offset, the
// result valid flag and all registers (pattern length resets to one).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wildcard_byte_pattern_scan_core
   import wbps_pkg::*;
#(
   parameter int unsigned PATTERN_MAX = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Input beats.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // last_byte
   // Result beats.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ADDR_WIDTH-1:0] rsp_tdata,   // [47:0] match_address
   output logic                  rsp_tuser,   // [0] found
   // Register writes.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [63:0]           csr_data
);

   localparam logic [LEN_WIDTH-1:0] LEN_MAX = LEN_WIDTH'(PATTERN_MAX);

   // Configuration registers.
   logic [63:0]            pat_low_ff, pat_low_in;
   logic [63:0]            pat_high_ff, pat_high_in;
   logic [PAT_BYTES-1:0]   wild_ff, wild_in;
   logic [LEN_WIDTH-1:0]   length_ff, length_in;
   logic [ADDR_WIDTH-1:0]  base_ff, base_in;

   // Scan state.
   logic [COUNT_WIDTH-1:0] seen_ff, seen_in;
   logic                   latched_ff, latched_in;
   logic [COUNT_WIDTH-1:0] offset_ff, offset_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [ADDR_WIDTH-1:0]  rsp_addr_ff, rsp_addr_in;

   logic                   req_accept;
   logic                   csr_write;
   logic [LEN_WIDTH-1:0]   used_len;
   logic [LEN_WIDTH-1:0]   len_m1;
   logic [127:0]           pat_all;
   logic [7:0]             pat_byte [PAT_BYTES];
   wbps_tap_type           taps [PATTERN_MAX];
   logic [7:0]             chain [PATTERN_MAX+1];
   logic [PATTERN_MAX-1:0] hits;
   logic                   match_now;
   logic [COUNT_WIDTH-1:0] offset_now;
   logic [COUNT_WIDTH-1:0] offset_sel;
   logic                   found_sel;
   logic [ADDR_WIDTH-1:0]  addr_sel;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      wild_in     = wild_ff;
      length_in   = length_ff;
      base_in     = base_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_in  = csr_data;
            CSR_PATTERN_HIGH: pat_high_in = csr_data;
            CSR_WILDCARD:     wild_in     = csr_data[PAT_BYTES-1:0];
            CSR_LENGTH:       length_in   = csr_data[LEN_WIDTH-1:0];
            CSR_BASE:         base_in     = csr_data[ADDR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Length in use: zero counts as one, and it saturates at the window depth.
   always_comb begin
      if (length_ff == '0) begin
         used_len = LEN_WIDTH'(1);
      end else if (length_ff > LEN_MAX) begin
         used_len = LEN_MAX;
      end else begin
         used_len = length_ff;
      end
   end
   assign len_m1  = used_len - LEN_WIDTH'(1);
   assign pat_all = {pat_high_ff, pat_low_ff};

   for (genvar j = 0; j < PAT_BYTES; j++) begin : g_pat
      assign pat_byte[j] = pat_all[8*j +: 8];
   end

   // Cell k holds the byte from k beats ago and faces pattern byte len-1-k.
   assign chain[0] = req_tdata;
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [LEN_WIDTH-1:0] tap_idx;
      assign tap_idx = len_m1 - LEN_WIDTH'(k);

      always_comb begin
         taps[k].pat_byte = pat_byte[tap_idx[3:0]];
         taps[k].care     = (LEN_WIDTH'(k) < used_len) && !wild_ff[tap_idx[3:0]];
      end

      wbps_cell u_cell (
         .clock    (clock),
         .shift_en (req_accept),
         .byte_in  (chain[k]),
         .tap      (taps[k]),
         .byte_out (chain[k+1]),
         .hit      (hits[k])
      );
   end

   // First match detection; the window is complete once len-1 bytes preceded.
   assign match_now  = !latched_ff && (seen_ff >= COUNT_WIDTH'(len_m1)) && (&hits);
   assign offset_now = seen_ff - COUNT_WIDTH'(len_m1);
   assign offset_sel = match_now ? offset_now : offset_ff;
   assign found_sel  = latched_ff || match_now;
   assign addr_sel   = base_ff + ADDR_WIDTH'(offset_sel);

   // Scan state update per beat; the last byte clears it for the next region.
   always_comb begin
      seen_in    = seen_ff;
      latched_in = latched_ff;
      offset_in  = offset_ff;
      if (req_accept) begin
         if (req_tlast) begin
            seen_in    = '0;
            latched_in = 1'b0;
            offset_in  = '0;
         end else begin
            if (seen_ff != '1) begin
               seen_in = seen_ff + COUNT_WIDTH'(1);
            end
            latched_in = found_sel;
            offset_in  = offset_sel;
         end
      end
   end

   // Output register, loaded by the last byte and freed when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (req_accept && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_sel;
         rsp_addr_in  = found_sel ? addr_sel : '0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         wild_ff      <= '0;
         length_ff    <= LEN_WIDTH'(1);
         base_ff      <= '0;
         seen_ff      <= '0;
         latched_ff   <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_low_ff   <= pat_low_in;
         pat_high_ff  <= pat_high_in;
         wild_ff      <= wild_in;
         length_ff    <= length_in;
         base_ff      <= base_in;
         seen_ff      <= seen_in;
         latched_ff   <= latched_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_addr_ff;

   // Checks on the scan and output logic.
   `ASSERT_IMPLIES(a_stall_blocks_input, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)
   `ASSERT_IMPLIES(a_not_found_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_addr_ff == '0)
   `ASSERT_NEXT(a_last_clears, clock, reset, req_accept && req_tlast, rsp_valid_ff && seen_ff == '0 && !latched_ff)
   `ASSERT_IMPLIES(a_latch_needs_bytes, clock, reset, latched_ff, seen_ff != '0)

endmodule

@@ verif/wildcard_byte_pattern_scan_core_tb.sv @@
// Testbench for the wildcard byte pattern scanner: directed and random region scans.
`timescale 1ns / 1ps
module wildcard_byte_pattern_scan_core_tb;
   import wbps_pkg::*;

   localparam int unsigned ITEM_GOAL   = 1150;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned HOLD_CYCLES = 300;

   // One scan result: the found flag and the match address.
   typedef struct packed {
      logic                  found;
      logic [ADDR_WIDTH-1:0] addr;
   } scan_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [ADDR_WIDTH-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [63:0]           csr_data;

   // Register copies used by the predictor.
   logic [63:0]           pat_low;
   logic [63:0]           pat_high;
   logic [15:0]           wild_mask;
   logic [LEN_WIDTH-1:0]  pat_len_raw;
   logic [ADDR_WIDTH-1:0] region_base;

   // Scan state of the predictor.
   logic [7:0]            window [16];
   logic [31:0]           seen_count;
   logic                  hit_latched;
   logic [31:0]           hit_offset;

   scan_result_type       pending_results [$];
   int unsigned           error_count = 0;
   int unsigned           bytes_sent = 0;
   int unsigned           cycle_count = 0;
   int unsigned           burst_left = 0;
   bit                    tx_gaps = 1'b0;
   bit                    hold_flag = 1'b0;

   wildcard_byte_pattern_scan_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run length guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Pattern length in use: zero counts as one, values above 16 saturate.
   function automatic int unsigned used_len();
      if (pat_len_raw == 0)
         return 1;
      if (pat_len_raw > PAT_BYTES)
         return PAT_BYTES;
      return pat_len_raw;
   endfunction

   function automatic void clear_scan();
      for (int k = 0; k < 16; k++)
         window[k] = 8'h00;
      seen_count  = '0;
      hit_latched = 1'b0;
      hit_offset  = '0;
   endfunction

   // Shifts one byte into the window, latches the first match and, on the
   // last byte, queues the expected result of the region.
   function automatic void scan_predict(input logic [7:0] data, input logic last);
      int unsigned     len;
      logic            hit;
      logic [127:0]    pat;
      scan_result_type res;
      len = used_len();
      pat = {pat_high, pat_low};
      for (int k = 15; k > 0; k--)
         window[k] = window[k-1];
      window[0] = data;
      if (!hit_latched && seen_count >= len - 1) begin
         hit = 1'b1;
         for (int j = 0; j < len; j++) begin
            if (!wild_mask[j] && window[len-1-j] != pat[8*j +: 8])
               hit = 1'b0;
         end
         if (hit) begin
            hit_latched = 1'b1;
            hit_offset  = seen_count - (len - 1);
         end
      end
      if (seen_count != 32'hFFFF_FFFF)
         seen_count = seen_count + 1;
      if (last) begin
         res.found = hit_latched;
         res.addr  = hit_latched ? region_base + {16'h0000, hit_offset} : '0;
         pending_results.insert(pending_results.size(), res);
         clear_scan();
      end
   endfunction

   // Result checker: every result beat is matched against the oldest expectation.
   always @(posedge clock) begin
      scan_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result beat found=%0b addr=%h", $time,
                     rsp_tuser, rsp_tdata);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_tuser !== exp_res.found) begin
               error_count++;
               $display("%0t: found mismatch expected %0b actual %0b", $time,
                        exp_res.found, rsp_tuser);
            end
            if (rsp_tdata !== exp_res.addr) begin
               error_count++;
               $display("%0t: match address mismatch expected %h actual %h", $time,
                        exp_res.addr, rsp_tdata);
            end
         end
      end
   end

   // Receiver: random stall patterns, plus a long hold-off on request.
   initial begin
      int unsigned rx_mode;
      int unsigned rx_left;
      rx_mode = 0;
      rx_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_flag) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_flag = 1'b0;
         end else begin
            if (rx_left == 0) begin
               rx_mode = $urandom_range(0, 2);
               rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= (rx_left % 8 < 3);
            endcase
         end
      end
   end

   // Offers one byte and waits until the block takes the beat.
   task automatic send_byte(input logic [7:0] data, input logic last);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      scan_predict(data, last);
      bytes_sent++;
   endtask

   task automatic idle_for(input int unsigned n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Sender bursts of random length with random gaps between them.
   task automatic pace_sender();
      if (tx_gaps) begin
         if (burst_left == 0) begin
            idle_for($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
   endtask

   // Stops offering and waits until every expected result has come.
   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Block is idle: nothing expected and the result register has settled.
   task automatic wait_idle();
      wait_drain();
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PATTERN_LOW:  pat_low     = value;
         CSR_PATTERN_HIGH: pat_high    = value;
         CSR_WILDCARD:     wild_mask   = value[15:0];
         CSR_LENGTH:       pat_len_raw = value[LEN_WIDTH-1:0];
         CSR_BASE:         region_base = value[ADDR_WIDTH-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sends one region of n bytes; filler leans toward pattern bytes, and the
   // pattern is planted at a random spot when asked and when it fits.
   task automatic run_region(input int unsigned n, input bit plant);
      logic [7:0]   bytes [$];
      logic [127:0] pat;
      int unsigned  len;
      int unsigned  pos;
      int unsigned  k;
      len = used_len();
      pat = {pat_high, pat_low};
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, len - 1);
         if ($urandom_range(0, 1) != 0)
            bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
         else
            bytes.insert(bytes.size(), pat[8*k +: 8]);
      end
      if (plant && n >= len) begin
         pos = $urandom_range(0, n - len);
         for (int j = 0; j < len; j++) begin
            if (!wild_mask[j])
               bytes[pos+j] = pat[8*j +: 8];
         end
      end
      for (int i = 0; i < n; i++) begin
         pace_sender();
         send_byte(bytes[i], i == n - 1);
      end
   endtask

   // Registers at reset: length one, pattern byte zero, base zero.
   task automatic test_reset_defaults();
      send_byte(8'h05, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h07, 1'b1);
      send_byte(8'hFF, 1'b1);
   endtask

   // Length zero acts as one; a second match is ignored; length above the
   // maximum saturates, and a region shorter than the pattern finds nothing.
   task automatic test_length_limits();
      wait_idle();
      csr_write(CSR_PATTERN_LOW, 64'h0000_0000_0000_00FF);
      csr_write(CSR_LENGTH, 64'd0);
      send_byte(8'h11, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_idle();
      csr_write(CSR_LENGTH, 64'd31);
      send_byte(8'hAB, 1'b0);
      send_byte(8'hAB, 1'b1);
   endtask

   // Match address wraps past the top of the 48-bit space.
   task automatic test_address_wrap();
      wait_idle();
      csr_write(CSR_PATTERN_LOW, 64'h0000_0000_0000_00AB);
      csr_write(CSR_LENGTH, 64'd1);
      csr_write(CSR_BASE, 64'h0000_FFFF_FFFF_FFFF);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAB, 1'b1);
   endtask

   // Wildcard byte matches anything; writes past the last register change nothing.
   task automatic test_wildcard_and_ignored_index();
      wait_idle();
      csr_write(CSR_PATTERN_LOW, 64'h0000_0000_0000_003C);
      csr_write(CSR_WILDCARD, 64'h0000_0000_0000_0002);
      csr_write(CSR_LENGTH, 64'd2);
      csr_write(CSR_BASE, 64'h0000_1234_5678_9ABC);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h99, 1'b1);
      wait_idle();
      csr_write(CSR_BASE + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(CSR_BASE + 3'd3, 64'hFFFF_FFFF_FFFF_FFFF);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h99, 1'b1);
   endtask

   // Receiver holds off while short regions keep coming, so the input stalls.
   task automatic test_backpressure();
      tx_gaps = 1'b0;
      hold_flag = 1'b1;
      for (int r = 0; r < 6; r++)
         run_region($urandom_range(1, 4), 1'b1);
      wait_drain();
   endtask

   // Loads a register setting; the first phases take the extremes.
   task automatic load_setting(input int unsigned phase);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [15:0] mask;
      logic [63:0] len;
      logic [63:0] base;
      lo   = {$urandom, $urandom};
      hi   = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: mask = 16'h0000;
         1: mask = 16'hFFFF;
         2: mask = 16'($urandom & $urandom);
         default: mask = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: len = 64'($urandom_range(0, 31));
         1: len = 64'd16;
         default: len = 64'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 3))
         0: base = 64'd0;
         1: base = 64'h0000_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
         default: base = {16'h0000, 16'($urandom), $urandom};
      endcase
      if (phase == 0) begin
         lo   = 64'hFFFF_FFFF_FFFF_FFFF;
         hi   = 64'hFFFF_FFFF_FFFF_FFFF;
         mask = 16'h0000;
         len  = 64'd16;
         base = 64'h0000_FFFF_FFFF_FFFF;
      end else if (phase == 1) begin
         lo   = 64'd0;
         hi   = 64'd0;
         mask = 16'hFFFF;
         len  = 64'd16;
         base = 64'd0;
      end else if (phase == 2) begin
         mask = 16'h0000;
         len  = 64'd1;
      end
      csr_write(CSR_PATTERN_LOW, lo);
      csr_write(CSR_PATTERN_HIGH, hi);
      csr_write(CSR_WILDCARD, {48'h0, mask});
      csr_write(CSR_LENGTH, len);
      csr_write(CSR_BASE, base);
      if ($urandom_range(0, 4) == 0)
         csr_write(CSR_BASE + 3'($urandom_range(1, 3)), {$urandom, $urandom});
   endtask

   // Random phases: a new setting, then a run of regions of random size.
   task automatic test_random_scan();
      int unsigned phase;
      int unsigned regions;
      int unsigned n;
      phase = 0;
      while (bytes_sent < ITEM_GOAL) begin
         wait_idle();
         load_setting(phase);
         tx_gaps = ($urandom_range(0, 3) != 0);
         regions = $urandom_range(5, 15);
         for (int r = 0; r < regions; r++) begin
            if ($urandom_range(0, 9) == 0)
               n = $urandom_range(17, 60);
            else
               n = $urandom_range(1, 20);
            run_region(n, $urandom_range(0, 9) < 7);
            if ($urandom_range(0, 9) == 0)
               wait_drain();
         end
         phase++;
      end
   endtask

   // Test sequence.
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_PATTERN_LOW;
      csr_data   = 64'd0;
      pat_low     = 64'd0;
      pat_high    = 64'd0;
      wild_mask   = 16'h0000;
      pat_len_raw = 5'd1;
      region_base = '0;
      clear_scan();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_length_limits();
      test_address_wrap();
      test_wildcard_and_ignored_index();
      test_backpressure();
      test_random_scan();

      wait_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
